>>> hdl/bfsb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block FIFO sample buffer package
// Shared sizes, command codes and transaction types for the block FIFO.
// ----------------------------------------------------------------------------
package bfsb_pkg;

  localparam int unsigned BLOCK_COUNT = 4;
  localparam int unsigned BLOCK_LEN   = 64;
  localparam int unsigned STORE_DEPTH = BLOCK_COUNT * BLOCK_LEN;

  localparam int unsigned BLK_W    = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
  localparam int unsigned OFF_W    = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;
  localparam int unsigned ADDR_W   = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned SAMPLE_W = 24;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic    cmd;
    sample_t sample_in;
  } req_t;

  typedef struct packed {
    logic    accepted;
    sample_t sample_out;
    logic    block_switched;
  } rsp_t;

  typedef struct packed {
    logic issue;
    logic respond;
  } dp_cmd_t;

endpackage

>>> hdl/bfsb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block FIFO controller
// Sequences one transaction: accept, then present the result for one cycle.
// ----------------------------------------------------------------------------
module bfsb_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  output bfsb_pkg::dp_cmd_t  dp_cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_RESP
  } state_e;

  state_e state_q;
  logic   busy_q;
  logic   issue;

  assign issue = start && (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q  <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            state_q <= ST_RESP;
            busy_q  <= 1'b1;
          end
        end
        ST_RESP: begin
          state_q <= ST_IDLE;
          busy_q  <= 1'b0;
        end
        default: begin
          state_q <= ST_IDLE;
          busy_q  <= 1'b0;
        end
      endcase
    end
  end

  assign busy             = busy_q;
  assign dp_cmd_o.issue   = issue;
  assign dp_cmd_o.respond = (state_q == ST_RESP);

endmodule

>>> hdl/bfsb_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block FIFO datapath
// Sample memory, block pointers, offsets and per-block full marks.
// ----------------------------------------------------------------------------
module bfsb_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bfsb_pkg::dp_cmd_t  dp_cmd_i,
  input  bfsb_pkg::req_t     req_i,
  output logic               done_o,
  output bfsb_pkg::rsp_t     rsp_o
);

  localparam logic [bfsb_pkg::BLK_W-1:0] LastBlk =
    bfsb_pkg::BLK_W'(bfsb_pkg::BLOCK_COUNT - 1);
  localparam logic [bfsb_pkg::OFF_W-1:0] LastOff =
    bfsb_pkg::OFF_W'(bfsb_pkg::BLOCK_LEN - 1);

  logic [bfsb_pkg::SAMPLE_W-1:0] mem [bfsb_pkg::STORE_DEPTH];
  logic [bfsb_pkg::SAMPLE_W-1:0] rd_data_q;

  logic [bfsb_pkg::BLOCK_COUNT-1:0] full_q, full_d;
  logic [bfsb_pkg::BLK_W-1:0] wr_blk_q, wr_blk_d, rd_blk_q, rd_blk_d;
  logic [bfsb_pkg::OFF_W-1:0] wr_off_q, wr_off_d, rd_off_q, rd_off_d;
  logic accepted_q, accepted_d, switched_q, switched_d, rd_sel_q, rd_sel_d;

  logic                       do_write, do_read;
  logic [bfsb_pkg::BLK_W-1:0] blk;
  logic [bfsb_pkg::OFF_W-1:0] off;
  logic [bfsb_pkg::ADDR_W-1:0] addr;

  assign do_write = dp_cmd_i.issue && (req_i.cmd == bfsb_pkg::CMD_WRITE) && !full_q[wr_blk_q];
  assign do_read  = dp_cmd_i.issue && (req_i.cmd == bfsb_pkg::CMD_READ) && full_q[rd_blk_q];
  assign blk  = (req_i.cmd == bfsb_pkg::CMD_WRITE) ? wr_blk_q : rd_blk_q;
  assign off  = (req_i.cmd == bfsb_pkg::CMD_WRITE) ? wr_off_q : rd_off_q;
  assign addr = bfsb_pkg::ADDR_W'(bfsb_pkg::ADDR_W'(blk) * bfsb_pkg::ADDR_W'(bfsb_pkg::BLOCK_LEN))
              + bfsb_pkg::ADDR_W'(off);

  always_comb begin
    full_d     = full_q;
    wr_blk_d   = wr_blk_q;
    wr_off_d   = wr_off_q;
    rd_blk_d   = rd_blk_q;
    rd_off_d   = rd_off_q;
    accepted_d = accepted_q;
    switched_d = switched_q;
    rd_sel_d   = rd_sel_q;
    if (dp_cmd_i.issue) begin
      accepted_d = do_write || do_read;
      switched_d = 1'b0;
      rd_sel_d   = do_read;
    end
    if (do_write) begin
      if (wr_off_q == LastOff) begin
        wr_off_d         = '0;
        full_d[wr_blk_q] = 1'b1;
        wr_blk_d         = (wr_blk_q == LastBlk) ? '0 : wr_blk_q + 1'b1;
        switched_d       = 1'b1;
      end else begin
        wr_off_d = wr_off_q + 1'b1;
      end
    end
    if (do_read) begin
      if (rd_off_q == LastOff) begin
        rd_off_d         = '0;
        full_d[rd_blk_q] = 1'b0;
        rd_blk_d         = (rd_blk_q == LastBlk) ? '0 : rd_blk_q + 1'b1;
        switched_d       = 1'b1;
      end else begin
        rd_off_d = rd_off_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q     <= '0;
      wr_blk_q   <= '0;
      wr_off_q   <= '0;
      rd_blk_q   <= '0;
      rd_off_q   <= '0;
      accepted_q <= 1'b0;
      switched_q <= 1'b0;
      rd_sel_q   <= 1'b0;
    end else begin
      full_q     <= full_d;
      wr_blk_q   <= wr_blk_d;
      wr_off_q   <= wr_off_d;
      rd_blk_q   <= rd_blk_d;
      rd_off_q   <= rd_off_d;
      accepted_q <= accepted_d;
      switched_q <= switched_d;
      rd_sel_q   <= rd_sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_write) begin
      mem[addr] <= req_i.sample_in;
    end
    if (do_read) begin
      rd_data_q <= mem[addr];
    end
  end

  assign done_o               = dp_cmd_i.respond;
  assign rsp_o.accepted       = accepted_q;
  assign rsp_o.sample_out     = rd_sel_q ? rd_data_q : '0;
  assign rsp_o.block_switched = switched_q;

endmodule

>>> hdl/block_fifo_sample_buffer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block FIFO sample buffer
// A ring of equal sample blocks, each written whole and read whole in turn.
// ----------------------------------------------------------------------------
// Usage: drive req_i (cmd and sample_in) and raise start. The transaction is
// taken at a clock edge where start is high and busy is low. A write stores the
// sample only if the current write block is empty; a read returns a sample only
// if the current read block is full. Filling or draining the last slot of a
// block flips its mark and moves that side to the next block of the ring.
// Exactly one result follows each transaction: done_o is high for one cycle,
// the cycle after acceptance, with rsp_o valid in that cycle.
// A new transaction is not taken before the result: busy is high during the
// result cycle, while the registered read port of the sample memory delivers
// its data. The result is taken at the edge that ends that cycle; the receiver
// cannot stall it.
// Reset marks every block empty and clears both pointers and offsets. The
// sample memory itself is not cleared, and a block is read only after all of
// its entries have been written.
// ----------------------------------------------------------------------------
module block_fifo_sample_buffer_top (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  bfsb_pkg::req_t  req_i,
  output logic            done_o,
  output bfsb_pkg::rsp_t  rsp_o
);

  bfsb_pkg::dp_cmd_t dp_cmd;

  bfsb_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .dp_cmd_o (dp_cmd)
  );

  bfsb_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .dp_cmd_i (dp_cmd),
    .req_i    (req_i),
    .done_o   (done_o),
    .rsp_o    (rsp_o)
  );

`ifndef SYNTHESIS
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> done_o)
    else $error("No result after an accepted transaction.");

  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("Result strobe held for more than one cycle.");

  a_switch_needs_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.block_switched) |-> rsp_o.accepted)
    else $error("Block switch reported on a refused transaction.");

  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !rsp_o.accepted) |-> (rsp_o.sample_out == '0))
    else $error("Refused transaction returned a nonzero sample.");
`endif

endmodule

>>> bench/tb_block_fifo_sample_buffer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block FIFO sample buffer testbench
// Drives write and read transactions into the block FIFO and keeps a mirror of
// its blocks, marks and pointers to predict every result. Each result is
// compared field by field with the oldest prediction. A short directed part is
// followed by whole fill and drain sequences and random traffic mixes, with the
// sender pausing at two different rates and then not at all.
// ----------------------------------------------------------------------------
module tb_block_fifo_sample_buffer_top;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned REPORT_CAP  = 100;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  bfsb_pkg::req_t   req_i = '0;
  logic             done_o;
  bfsb_pkg::rsp_t   rsp_o;

  logic [bfsb_pkg::SAMPLE_W-1:0] mirror_store [bfsb_pkg::STORE_DEPTH];
  logic                          mirror_full  [bfsb_pkg::BLOCK_COUNT];
  int unsigned                   mirror_wblk;
  int unsigned                   mirror_woff;
  int unsigned                   mirror_rblk;
  int unsigned                   mirror_roff;

  bfsb_pkg::rsp_t access_results_q[$];
  bfsb_pkg::rsp_t oldest_rsp;
  int unsigned    idle_pct;
  int unsigned    error_count = 0;
  int unsigned    cycle_count = 0;
  int unsigned    stored_writes;
  int unsigned    dropped_writes;
  int unsigned    served_reads;
  int unsigned    refused_reads;
  int unsigned    block_flips;

  block_fifo_sample_buffer_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run did not complete within %0d cycles", $time, CYCLE_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic bfsb_pkg::rsp_t apply_access(bfsb_pkg::req_t r);
    bfsb_pkg::rsp_t res;
    int unsigned    idx;
    res = '0;
    if (r.cmd == bfsb_pkg::CMD_WRITE) begin
      if (!mirror_full[mirror_wblk]) begin
        idx = mirror_wblk * bfsb_pkg::BLOCK_LEN + mirror_woff;
        mirror_store[idx] = r.sample_in;
        res.accepted = 1'b1;
        if (mirror_woff == bfsb_pkg::BLOCK_LEN - 1) begin
          mirror_woff = 0;
          mirror_full[mirror_wblk] = 1'b1;
          mirror_wblk = (mirror_wblk == bfsb_pkg::BLOCK_COUNT - 1) ? 0 : mirror_wblk + 1;
          res.block_switched = 1'b1;
        end else begin
          mirror_woff = mirror_woff + 1;
        end
      end
    end else begin
      if (mirror_full[mirror_rblk]) begin
        idx = mirror_rblk * bfsb_pkg::BLOCK_LEN + mirror_roff;
        res.sample_out = mirror_store[idx];
        res.accepted = 1'b1;
        if (mirror_roff == bfsb_pkg::BLOCK_LEN - 1) begin
          mirror_roff = 0;
          mirror_full[mirror_rblk] = 1'b0;
          mirror_rblk = (mirror_rblk == bfsb_pkg::BLOCK_COUNT - 1) ? 0 : mirror_rblk + 1;
          res.block_switched = 1'b1;
        end else begin
          mirror_roff = mirror_roff + 1;
        end
      end
    end
    return res;
  endfunction

  function automatic bfsb_pkg::sample_t pick_sample();
    logic [31:0] raw;
    raw = $urandom;
    case ($urandom_range(7))
      0: return bfsb_pkg::sample_t'(24'h7FFFFF);
      1: return bfsb_pkg::sample_t'(24'h800000);
      2: return bfsb_pkg::sample_t'(raw[0] ? 24'hFFFFFF : 24'h000000);
      default: return bfsb_pkg::sample_t'(raw[bfsb_pkg::SAMPLE_W-1:0]);
    endcase
  endfunction

  task automatic send_access(logic cmd, bfsb_pkg::sample_t sample);
    bfsb_pkg::req_t r;
    bfsb_pkg::rsp_t res;
    r.cmd = cmd;
    r.sample_in = sample;
    req_i <= r;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    res = apply_access(r);
    access_results_q.push_back(res);
    if (cmd == bfsb_pkg::CMD_WRITE) begin
      if (res.accepted) stored_writes++;
      else dropped_writes++;
    end else begin
      if (res.accepted) served_reads++;
      else refused_reads++;
    end
    if (res.block_switched) block_flips++;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic report_field(string name, logic [31:0] expv, logic [31:0] actv);
    error_count++;
    if (error_count <= REPORT_CAP) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, expv, actv);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      if (access_results_q.size() == 0) begin
        report_field("unexpected result, accepted", 32'h0, 32'(rsp_o.accepted));
      end else begin
        oldest_rsp = access_results_q.pop_front();
        if (rsp_o.accepted !== oldest_rsp.accepted)
          report_field("accepted", 32'(oldest_rsp.accepted), 32'(rsp_o.accepted));
        if (rsp_o.sample_out !== oldest_rsp.sample_out)
          report_field("sample_out", 32'(unsigned'(oldest_rsp.sample_out)),
                       32'(unsigned'(rsp_o.sample_out)));
        if (rsp_o.block_switched !== oldest_rsp.block_switched)
          report_field("block_switched", 32'(oldest_rsp.block_switched),
                       32'(rsp_o.block_switched));
      end
    end
  end

  // Reads on an empty FIFO, extreme samples, and a read of a partly written block.
  task automatic test_refused_and_extremes();
    send_access(bfsb_pkg::CMD_READ, bfsb_pkg::sample_t'(24'hFFFFFF));
    send_access(bfsb_pkg::CMD_READ, bfsb_pkg::sample_t'(24'h000000));
    send_access(bfsb_pkg::CMD_WRITE, bfsb_pkg::sample_t'(24'h7FFFFF));
    send_access(bfsb_pkg::CMD_WRITE, bfsb_pkg::sample_t'(24'h800000));
    send_access(bfsb_pkg::CMD_WRITE, bfsb_pkg::sample_t'(24'h000000));
    send_access(bfsb_pkg::CMD_WRITE, bfsb_pkg::sample_t'(24'hFFFFFF));
    send_access(bfsb_pkg::CMD_WRITE, bfsb_pkg::sample_t'(24'h555555));
    send_access(bfsb_pkg::CMD_WRITE, bfsb_pkg::sample_t'(24'hAAAAAA));
    send_access(bfsb_pkg::CMD_READ, bfsb_pkg::sample_t'(24'h123456));
  endtask

  // Fill every block, overflow the ring, drain every block, then underflow it.
  task automatic test_fill_and_drain();
    while (!mirror_full[mirror_wblk]) send_access(bfsb_pkg::CMD_WRITE, pick_sample());
    repeat (3) send_access(bfsb_pkg::CMD_WRITE, pick_sample());
    send_access(bfsb_pkg::CMD_READ, pick_sample());
    send_access(bfsb_pkg::CMD_WRITE, pick_sample());
    while (mirror_full[mirror_rblk]) send_access(bfsb_pkg::CMD_READ, pick_sample());
    repeat (2) send_access(bfsb_pkg::CMD_READ, pick_sample());
  endtask

  // Random bursts of one command, with reads chosen at the given percentage.
  task automatic test_mixed_traffic(int unsigned count, int unsigned read_pct);
    int unsigned sent;
    int unsigned burst;
    logic        cmd;
    sent = 0;
    while (sent < count) begin
      cmd = ($urandom_range(99) < read_pct) ? bfsb_pkg::CMD_READ : bfsb_pkg::CMD_WRITE;
      burst = ($urandom_range(3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 8);
      repeat (burst) begin
        send_access(cmd, pick_sample());
        sent++;
      end
    end
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    while (access_results_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  initial begin
    for (int i = 0; i < bfsb_pkg::BLOCK_COUNT; i++) mirror_full[i] = 1'b0;
    mirror_wblk = 0;
    mirror_woff = 0;
    mirror_rblk = 0;
    mirror_roff = 0;
    stored_writes = 0;
    dropped_writes = 0;
    served_reads = 0;
    refused_reads = 0;
    block_flips = 0;
    idle_pct = 12;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_refused_and_extremes();
    test_fill_and_drain();
    test_mixed_traffic(300, 35);
    idle_pct = 46;
    test_mixed_traffic(300, 65);
    test_fill_and_drain();
    idle_pct = 0;
    test_mixed_traffic(300, 50);
    test_mixed_traffic(100, 30);
    wait_for_results();

    $display("Covered %0d stored and %0d dropped writes, %0d served and %0d refused reads,",
             stored_writes, dropped_writes, served_reads, refused_reads);
    $display("with %0d block switches around the ring and %0d mismatching fields.",
             block_flips, error_count);
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/bfsb_pkg.sv
hdl/bfsb_ctrl.sv
hdl/bfsb_dp.sv
hdl/block_fifo_sample_buffer_top.sv
bench/tb_block_fifo_sample_buffer_top.sv
